@@ rtl/binary_lifting_lca_core_defines.svh @@
// assertion macros shared by the lowest-common-ancestor core
`ifndef BINARY_LIFTING_LCA_CORE_DEFINES_SVH
`define BINARY_LIFTING_LCA_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define BLCA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define BLCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/blca_pkg.sv @@
// shared constants, codes, types and helpers of the lowest-common-ancestor core
`timescale 1ns / 1ps
package blca_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;

  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int LVL_W     = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ANC_DEPTH = LIFT_LEVELS * MAX_NODES;
  localparam int ANC_AW    = (ANC_DEPTH > 1) ? $clog2(ANC_DEPTH) : 1;
  localparam int ACC_W     = ((LIFT_LEVELS > NODE_W) ? LIFT_LEVELS : NODE_W) + 1;

  // stream payload widths
  localparam int CMD_W    = 2;
  localparam int S_DATA_W = ((2 * NODE_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((NODE_W + 7) / 8) * 8;

  // register port
  localparam int CFG_W     = 11;
  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  // datapath operations issued by the controller
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] OP_NONE        = 5'd0;
  localparam logic [OP_W-1:0] OP_LOAD        = 5'd1;
  localparam logic [OP_W-1:0] OP_BUILD_INIT  = 5'd2;
  localparam logic [OP_W-1:0] OP_QUERY_INIT  = 5'd3;
  localparam logic [OP_W-1:0] OP_FIX_RD      = 5'd4;
  localparam logic [OP_W-1:0] OP_FIX_WR      = 5'd5;
  localparam logic [OP_W-1:0] OP_LIFT_RD1    = 5'd6;
  localparam logic [OP_W-1:0] OP_LIFT_RD2    = 5'd7;
  localparam logic [OP_W-1:0] OP_LIFT_WR     = 5'd8;
  localparam logic [OP_W-1:0] OP_DEPTH_INIT  = 5'd9;
  localparam logic [OP_W-1:0] OP_DEPTH_START = 5'd10;
  localparam logic [OP_W-1:0] OP_DEPTH_RD    = 5'd11;
  localparam logic [OP_W-1:0] OP_DEPTH_UP    = 5'd12;
  localparam logic [OP_W-1:0] OP_DEPTH_WR    = 5'd13;
  localparam logic [OP_W-1:0] OP_Q_RDA       = 5'd14;
  localparam logic [OP_W-1:0] OP_Q_RDB       = 5'd15;
  localparam logic [OP_W-1:0] OP_Q_CMP       = 5'd16;
  localparam logic [OP_W-1:0] OP_Q_ALIGN     = 5'd17;
  localparam logic [OP_W-1:0] OP_Q_ALIGN_UP  = 5'd18;
  localparam logic [OP_W-1:0] OP_Q_EQ        = 5'd19;
  localparam logic [OP_W-1:0] OP_Q_LA        = 5'd20;
  localparam logic [OP_W-1:0] OP_Q_LB        = 5'd21;
  localparam logic [OP_W-1:0] OP_Q_LC        = 5'd22;
  localparam logic [OP_W-1:0] OP_Q_PR        = 5'd23;
  localparam logic [OP_W-1:0] OP_Q_PW        = 5'd24;
  localparam logic [OP_W-1:0] OP_PUSH        = 5'd25;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic idx_last;
    logic lvl_last;
    logic lvl_zero;
    logic n_one;
    logic diff_bit;
    logic query_err;
    logic nodes_eq;
    logic out_free;
  } dp_stat_t;

  // ancestor table entry of a node at a lift level
  function automatic logic [ANC_AW-1:0] anc_addr(input logic [LVL_W-1:0] lvl,
                                                 input logic [NODE_W-1:0] node);
    return ANC_AW'(lvl) * ANC_AW'(MAX_NODES) + ANC_AW'(node);
  endfunction

endpackage

@@ rtl/blca_ram.sv @@
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module blca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/blca_ctrl.sv @@
// sequencer for load, build and query transactions of the ancestor core
`timescale 1ns / 1ps
module blca_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic [blca_pkg::CMD_W-1:0]  s_cmd,
  output logic                        s_tready,
  input  blca_pkg::dp_stat_t          stat,
  output blca_pkg::ctrl_cmd_t         cmd
);
  import blca_pkg::*;

  localparam int STATE_W = 5;
  localparam logic [STATE_W-1:0] ST_IDLE      = 5'd0;
  localparam logic [STATE_W-1:0] ST_FIX_RD    = 5'd1;
  localparam logic [STATE_W-1:0] ST_FIX_WR    = 5'd2;
  localparam logic [STATE_W-1:0] ST_LIFT_RD1  = 5'd3;
  localparam logic [STATE_W-1:0] ST_LIFT_RD2  = 5'd4;
  localparam logic [STATE_W-1:0] ST_LIFT_WR   = 5'd5;
  localparam logic [STATE_W-1:0] ST_DEP_INIT  = 5'd6;
  localparam logic [STATE_W-1:0] ST_DEP_START = 5'd7;
  localparam logic [STATE_W-1:0] ST_DEP_RD    = 5'd8;
  localparam logic [STATE_W-1:0] ST_DEP_UP    = 5'd9;
  localparam logic [STATE_W-1:0] ST_DEP_WR    = 5'd10;
  localparam logic [STATE_W-1:0] ST_Q_RDA     = 5'd11;
  localparam logic [STATE_W-1:0] ST_Q_RDB     = 5'd12;
  localparam logic [STATE_W-1:0] ST_Q_CMP     = 5'd13;
  localparam logic [STATE_W-1:0] ST_Q_ALIGN   = 5'd14;
  localparam logic [STATE_W-1:0] ST_Q_ALUP    = 5'd15;
  localparam logic [STATE_W-1:0] ST_Q_EQ      = 5'd16;
  localparam logic [STATE_W-1:0] ST_Q_LA      = 5'd17;
  localparam logic [STATE_W-1:0] ST_Q_LB      = 5'd18;
  localparam logic [STATE_W-1:0] ST_Q_LC      = 5'd19;
  localparam logic [STATE_W-1:0] ST_Q_PR      = 5'd20;
  localparam logic [STATE_W-1:0] ST_Q_PW      = 5'd21;
  localparam logic [STATE_W-1:0] ST_Q_DONE    = 5'd22;

  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (s_cmd)
            CMD_LOAD: begin
              cmd.op = OP_LOAD;
            end
            CMD_BUILD: begin
              cmd.op     = OP_BUILD_INIT;
              state_next = ST_FIX_RD;
            end
            CMD_QUERY: begin
              cmd.op     = OP_QUERY_INIT;
              state_next = stat.query_err ? ST_Q_DONE : ST_Q_RDA;
            end
            default: begin
              cmd.op = OP_NONE;
            end
          endcase
        end
      end
      ST_FIX_RD: begin
        cmd.op     = OP_FIX_RD;
        state_next = ST_FIX_WR;
      end
      ST_FIX_WR: begin
        cmd.op = OP_FIX_WR;
        if (stat.idx_last) begin
          state_next = (LIFT_LEVELS > 1) ? ST_LIFT_RD1 : ST_DEP_INIT;
        end else begin
          state_next = ST_FIX_RD;
        end
      end
      ST_LIFT_RD1: begin
        cmd.op     = OP_LIFT_RD1;
        state_next = ST_LIFT_RD2;
      end
      ST_LIFT_RD2: begin
        cmd.op     = OP_LIFT_RD2;
        state_next = ST_LIFT_WR;
      end
      ST_LIFT_WR: begin
        cmd.op     = OP_LIFT_WR;
        state_next = (stat.idx_last && stat.lvl_last) ? ST_DEP_INIT : ST_LIFT_RD1;
      end
      ST_DEP_INIT: begin
        cmd.op     = OP_DEPTH_INIT;
        state_next = stat.n_one ? ST_IDLE : ST_DEP_START;
      end
      ST_DEP_START: begin
        cmd.op     = OP_DEPTH_START;
        state_next = ST_DEP_RD;
      end
      ST_DEP_RD: begin
        cmd.op     = OP_DEPTH_RD;
        state_next = ST_DEP_UP;
      end
      ST_DEP_UP: begin
        cmd.op     = OP_DEPTH_UP;
        state_next = stat.lvl_zero ? ST_DEP_WR : ST_DEP_RD;
      end
      ST_DEP_WR: begin
        cmd.op     = OP_DEPTH_WR;
        state_next = stat.idx_last ? ST_IDLE : ST_DEP_START;
      end
      ST_Q_RDA: begin
        cmd.op     = OP_Q_RDA;
        state_next = ST_Q_RDB;
      end
      ST_Q_RDB: begin
        cmd.op     = OP_Q_RDB;
        state_next = ST_Q_CMP;
      end
      ST_Q_CMP: begin
        cmd.op     = OP_Q_CMP;
        state_next = ST_Q_ALIGN;
      end
      ST_Q_ALIGN: begin
        cmd.op = OP_Q_ALIGN;
        if (stat.diff_bit) begin
          state_next = ST_Q_ALUP;
        end else if (stat.lvl_last) begin
          state_next = ST_Q_EQ;
        end
      end
      ST_Q_ALUP: begin
        cmd.op     = OP_Q_ALIGN_UP;
        state_next = stat.lvl_last ? ST_Q_EQ : ST_Q_ALIGN;
      end
      ST_Q_EQ: begin
        cmd.op     = OP_Q_EQ;
        state_next = stat.nodes_eq ? ST_Q_DONE : ST_Q_LA;
      end
      ST_Q_LA: begin
        cmd.op     = OP_Q_LA;
        state_next = ST_Q_LB;
      end
      ST_Q_LB: begin
        cmd.op     = OP_Q_LB;
        state_next = ST_Q_LC;
      end
      ST_Q_LC: begin
        cmd.op     = OP_Q_LC;
        state_next = stat.lvl_zero ? ST_Q_PR : ST_Q_LA;
      end
      ST_Q_PR: begin
        cmd.op     = OP_Q_PR;
        state_next = ST_Q_PW;
      end
      ST_Q_PW: begin
        cmd.op     = OP_Q_PW;
        state_next = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        if (stat.out_free) begin
          cmd.op     = OP_PUSH;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/blca_dp.sv @@
// datapath: node registers, counters, register port and result register
`timescale 1ns / 1ps
module blca_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  blca_pkg::ctrl_cmd_t           cmd,
  output blca_pkg::dp_stat_t            stat,
  input  logic [blca_pkg::NODE_W-1:0]   in_a,
  input  logic [blca_pkg::NODE_W-1:0]   in_b,
  output logic                          anc_we,
  output logic [blca_pkg::ANC_AW-1:0]   anc_waddr,
  output logic [blca_pkg::NODE_W-1:0]   anc_wdata,
  output logic [blca_pkg::ANC_AW-1:0]   anc_raddr,
  input  logic [blca_pkg::NODE_W-1:0]   anc_rdata,
  output logic                          dep_we,
  output logic [blca_pkg::NODE_W-1:0]   dep_waddr,
  output logic [blca_pkg::NODE_W-1:0]   dep_wdata,
  output logic [blca_pkg::NODE_W-1:0]   dep_raddr,
  input  logic [blca_pkg::NODE_W-1:0]   dep_rdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blca_pkg::PADDR_W-1:0]  paddr,
  input  logic [blca_pkg::APB_W-1:0]    pwdata,
  output logic [blca_pkg::APB_W-1:0]    prdata,
  input  logic                          m_tready,
  output logic                          out_valid,
  output logic [blca_pkg::NODE_W-1:0]   out_node,
  output logic                          out_err
);
  import blca_pkg::*;

  logic [CFG_W-1:0]  node_count;
  logic [CNT_W-1:0]  n_used;
  logic              built;
  logic [NODE_W-1:0] idx;
  logic [LVL_W-1:0]  lvl;
  logic [NODE_W-1:0] xa;
  logic [NODE_W-1:0] xb;
  logic [NODE_W-1:0] tmp;
  logic [ACC_W-1:0]  dacc;
  logic [NODE_W-1:0] da;
  logic [NODE_W-1:0] diff;
  logic [NODE_W-1:0] res_node;
  logic              res_err;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic [CFG_W-1:0]     wr_count;
  logic [CNT_W-1:0]     wr_n;
  logic                 load_ok;
  logic                 query_err;
  logic [NODE_W-1:0]    fix_val;
  logic [ACC_W-1:0]     dsum;
  logic [NODE_W-1:0]    dep_sat;
  logic [NODE_W-1:0]    diff_sh;
  logic [LVL_W-1:0]     lvl_m1;
  logic                 lvl_last;
  logic                 lvl_zero;
  logic                 idx_last;

  // register port decode
  assign reg_idx  = paddr[PADDR_W-1:2];
  assign cfg_wr   = psel && penable && pwrite && (reg_idx == REG_NODE_COUNT);
  assign wr_count = pwdata[CFG_W-1:0];
  assign prdata   = (reg_idx == REG_NODE_COUNT) ? APB_W'(node_count) : '0;

  // effective node count, saturated to [1, MAX_NODES]
  always_comb begin
    if (wr_count == '0) begin
      wr_n = CNT_W'(1);
    end else if (int'(wr_count) > MAX_NODES) begin
      wr_n = CNT_W'(MAX_NODES);
    end else begin
      wr_n = CNT_W'(wr_count);
    end
  end

  assign load_ok   = (in_a != '0) && ({1'b0, in_a} < n_used) && ({1'b0, in_b} < n_used);
  assign query_err = !built || ({1'b0, in_a} >= n_used) || ({1'b0, in_b} >= n_used);
  assign fix_val   = ((idx == '0) || ({1'b0, anc_rdata} >= n_used)) ? '0 : anc_rdata;
  assign dsum      = dacc + ACC_W'(1);
  assign dep_sat   = (dsum > ACC_W'(MAX_NODES - 1)) ? NODE_W'(MAX_NODES - 1)
                                                    : dsum[NODE_W-1:0];
  assign diff_sh   = diff >> lvl;
  assign lvl_m1    = lvl - LVL_W'(1);
  assign lvl_last  = (lvl == LVL_W'(LIFT_LEVELS - 1));
  assign lvl_zero  = (lvl == '0);
  assign idx_last  = ({1'b0, idx} == (n_used - CNT_W'(1)));

  always_comb begin
    stat.idx_last  = idx_last;
    stat.lvl_last  = lvl_last;
    stat.lvl_zero  = lvl_zero;
    stat.n_one     = (n_used == CNT_W'(1));
    stat.diff_bit  = diff_sh[0];
    stat.query_err = query_err;
    stat.nodes_eq  = (xa == xb);
    stat.out_free  = !out_valid || m_tready;
  end

  // memory port selection
  always_comb begin
    anc_we    = 1'b0;
    anc_waddr = anc_addr(lvl, idx);
    anc_wdata = anc_rdata;
    anc_raddr = anc_addr(lvl, xa);
    dep_we    = 1'b0;
    dep_waddr = idx;
    dep_wdata = dep_sat;
    dep_raddr = xa;
    unique case (cmd.op)
      OP_LOAD: begin
        anc_we    = load_ok;
        anc_waddr = anc_addr(LVL_W'(0), in_a);
        anc_wdata = in_b;
      end
      OP_FIX_RD: begin
        anc_raddr = anc_addr(lvl, idx);
      end
      OP_FIX_WR: begin
        anc_we    = 1'b1;
        anc_wdata = fix_val;
      end
      OP_LIFT_RD1: begin
        anc_raddr = anc_addr(lvl_m1, idx);
      end
      OP_LIFT_RD2: begin
        anc_raddr = anc_addr(lvl_m1, anc_rdata);
      end
      OP_LIFT_WR: begin
        anc_we = 1'b1;
      end
      OP_DEPTH_INIT: begin
        dep_we    = 1'b1;
        dep_waddr = '0;
        dep_wdata = '0;
      end
      OP_DEPTH_WR: begin
        dep_we = 1'b1;
      end
      OP_Q_RDB: begin
        dep_raddr = xb;
      end
      OP_Q_LB: begin
        anc_raddr = anc_addr(lvl, xb);
      end
      default: begin
        anc_we = 1'b0;
      end
    endcase
  end

  // control state: count register, built flag, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= CFG_W'(1);
      n_used     <= CNT_W'(1);
      built      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr) begin
        node_count <= wr_count;
        n_used     <= wr_n;
        built      <= 1'b0;
      end else if (cmd.op == OP_LOAD && load_ok) begin
        built <= 1'b0;
      end else if ((cmd.op == OP_DEPTH_INIT && n_used == CNT_W'(1)) ||
                   (cmd.op == OP_DEPTH_WR && idx_last)) begin
        built <= 1'b1;
      end
      if (cmd.op == OP_PUSH) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_BUILD_INIT: begin
        idx <= '0;
        lvl <= '0;
      end
      OP_QUERY_INIT: begin
        xa <= in_a;
        xb <= in_b;
        if (query_err) begin
          res_node <= '0;
          res_err  <= 1'b1;
        end
      end
      OP_FIX_WR: begin
        if (idx_last) begin
          idx <= '0;
          lvl <= LVL_W'(1);
        end else begin
          idx <= idx + NODE_W'(1);
        end
      end
      OP_LIFT_WR: begin
        if (idx_last) begin
          idx <= '0;
          lvl <= lvl + LVL_W'(1);
        end else begin
          idx <= idx + NODE_W'(1);
        end
      end
      OP_DEPTH_INIT: begin
        idx <= NODE_W'(1);
      end
      OP_DEPTH_START: begin
        xa   <= idx;
        dacc <= '0;
        lvl  <= LVL_W'(LIFT_LEVELS - 1);
      end
      OP_DEPTH_UP: begin
        if (anc_rdata != '0) begin
          xa   <= anc_rdata;
          dacc <= dacc + (ACC_W'(1) << lvl);
        end
        if (!lvl_zero) begin
          lvl <= lvl_m1;
        end
      end
      OP_DEPTH_WR: begin
        if (!idx_last) begin
          idx <= idx + NODE_W'(1);
        end
      end
      OP_Q_RDB: begin
        da <= dep_rdata;
      end
      OP_Q_CMP: begin
        // deeper node goes to xa
        if (da < dep_rdata) begin
          xa   <= xb;
          xb   <= xa;
          diff <= dep_rdata - da;
        end else begin
          diff <= da - dep_rdata;
        end
        lvl <= '0;
      end
      OP_Q_ALIGN: begin
        if (!diff_sh[0] && !lvl_last) begin
          lvl <= lvl + LVL_W'(1);
        end
      end
      OP_Q_ALIGN_UP: begin
        xa <= anc_rdata;
        if (!lvl_last) begin
          lvl <= lvl + LVL_W'(1);
        end
      end
      OP_Q_EQ: begin
        if (xa == xb) begin
          res_node <= xa;
          res_err  <= 1'b0;
        end else begin
          lvl <= LVL_W'(LIFT_LEVELS - 1);
        end
      end
      OP_Q_LB: begin
        tmp <= anc_rdata;
      end
      OP_Q_LC: begin
        if (tmp != anc_rdata) begin
          xa <= tmp;
          xb <= anc_rdata;
        end
        if (!lvl_zero) begin
          lvl <= lvl_m1;
        end
      end
      OP_Q_PW: begin
        res_node <= anc_rdata;
        res_err  <= 1'b0;
      end
      OP_PUSH: begin
        out_node <= res_node;
        out_err  <= res_err;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/binary_lifting_lca_core.sv @@
// lowest-common-ancestor core: binary-lifting tables over a loaded parent tree
// load and ignored commands leave the core idle and ready; a query or build holds the input until done
// an invalid query goes straight to the error result; a valid one aligns the deeper node, then
// lifts both nodes level by level and takes the parent; a build fixes the parent row, fills
// the lift rows above it and then the depth table; a result waits for a free output slot
// rst (synchronous) clears control, node_count to 1 and the built flag; rams are not cleared
`timescale 1ns / 1ps
`include "binary_lifting_lca_core_defines.svh"
module binary_lifting_lca_core (
  input  logic                           clk,
  input  logic                           rst,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [blca_pkg::S_DATA_W-1:0]  s_tdata,   // node_a [9:0], node_b [19:10], zero pad
  input  logic [blca_pkg::CMD_W-1:0]     s_tuser,   // cmd [1:0]
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [blca_pkg::M_DATA_W-1:0]  m_tdata,   // common_ancestor [9:0], zero pad
  output logic [0:0]                     m_tuser,   // status [0]
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [blca_pkg::PADDR_W-1:0]   paddr,
  input  logic [blca_pkg::APB_W-1:0]     pwdata,
  output logic [blca_pkg::APB_W-1:0]     prdata,
  output logic                           pready
);
  import blca_pkg::*;

  ctrl_cmd_t         ctrl_cmd;
  dp_stat_t          dp_stat;

  // ancestor table: LIFT_LEVELS rows of MAX_NODES entries, row 0 is the parent table
  logic              anc_we;
  logic [ANC_AW-1:0] anc_waddr;
  logic [NODE_W-1:0] anc_wdata;
  logic [ANC_AW-1:0] anc_raddr;
  logic [NODE_W-1:0] anc_rdata;

  // node depth table, written by a build
  logic              dep_we;
  logic [NODE_W-1:0] dep_waddr;
  logic [NODE_W-1:0] dep_wdata;
  logic [NODE_W-1:0] dep_raddr;
  logic [NODE_W-1:0] dep_rdata;

  logic              out_valid;
  logic [NODE_W-1:0] out_node;
  logic              out_err;

  // register port never waits
  assign pready = 1'b1;

  // sequencer: accepts a transaction only when idle
  blca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_cmd    (s_tuser),
    .s_tready (s_tready),
    .stat     (dp_stat),
    .cmd      (ctrl_cmd)
  );

  // datapath: node registers, level and index counters, result register
  blca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctrl_cmd),
    .stat      (dp_stat),
    .in_a      (s_tdata[NODE_W-1:0]),
    .in_b      (s_tdata[2*NODE_W-1:NODE_W]),
    .anc_we    (anc_we),
    .anc_waddr (anc_waddr),
    .anc_wdata (anc_wdata),
    .anc_raddr (anc_raddr),
    .anc_rdata (anc_rdata),
    .dep_we    (dep_we),
    .dep_waddr (dep_waddr),
    .dep_wdata (dep_wdata),
    .dep_raddr (dep_raddr),
    .dep_rdata (dep_rdata),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .m_tready  (m_tready),
    .out_valid (out_valid),
    .out_node  (out_node),
    .out_err   (out_err)
  );

  blca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (ANC_DEPTH)
  ) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr (anc_waddr),
    .wdata (anc_wdata),
    .raddr (anc_raddr),
    .rdata (anc_rdata)
  );

  blca_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_dep_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  // result register drives the master side
  assign m_tvalid = out_valid;
  assign m_tdata  = M_DATA_W'(out_node);
  assign m_tuser  = out_err;

  // a new result is loaded only when the output slot is empty or draining
  `BLCA_ASSERT_SAME(a_push_free, ctrl_cmd.op == OP_PUSH, !m_tvalid || m_tready, "result overwritten")
  // an accepted query always moves the sequencer out of idle
  `BLCA_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && s_tuser == CMD_QUERY, !s_tready, "query not held")
  // an error result carries node zero
  `BLCA_ASSERT_SAME(a_err_zero, m_tvalid && m_tuser[0], m_tdata == '0, "error result not zero")

endmodule
